>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond holds at an edge -> prop holds at the same edge
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("implication check failed");
// prop holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("invariant check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_ALWAYS(label, clk, rst, prop)
`endif
`endif

>>> src/lsmt_pkg.sv
// ---------------------------------------------------------------------------
// lsmt_pkg
// Types and fixed constants of the LCD scanline mode timer.
// ---------------------------------------------------------------------------
`default_nettype none

package lsmt_pkg;

  // dot counter width, enough for the largest line length
  localparam int DOT_W  = 10;
  localparam int LINE_W = 8;

  // dot thresholds inside a visible line
  localparam logic [DOT_W:0] OAM_END  = 11'd80;
  localparam logic [DOT_W:0] XFER_END = 11'd256;
  // first vblank line is the one after this
  localparam logic [LINE_W-1:0] LAST_VISIBLE_LINE = 8'd143;

  // status enable bit positions
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_COINC  = 3;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] dots_elapsed;
    logic       lcd_on;
    logic [7:0] compare_line;
    logic [3:0] stat_enables;
  } item_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] current_line;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
    logic       oam_scan_start;
    logic       draw_line_start;
    logic [7:0] draw_line_index;
  } result_t;

endpackage

`default_nettype wire

>>> src/lsmt_stream_if.sv
// ---------------------------------------------------------------------------
// lsmt_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface lsmt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/lsmt_core.sv
// ---------------------------------------------------------------------------
// lsmt_core
// Timing state and single-pass next-state / result logic for one beat.
// ---------------------------------------------------------------------------
`default_nettype none

module lsmt_core #(
  parameter int DOTS_PER_LINE   = 456,
  parameter int LINES_PER_FRAME = 154
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire lsmt_pkg::item_t   item,
  output lsmt_pkg::result_t      res
);

  localparam int DW = lsmt_pkg::DOT_W;
  localparam int LW = lsmt_pkg::LINE_W;

  // state
  logic [DW-1:0]   dot_count, dot_count_next;
  logic [LW-1:0]   line_count, line_count_next;
  lsmt_pkg::mode_t held_mode, held_mode_next;
  logic            frame_toggle, frame_toggle_next;
  logic            compare_fired, compare_fired_next;

  logic [DW:0]     dot_sum;
  logic [LW:0]     line_inc;
  logic [LW-1:0]   line_wrapped;
  lsmt_pkg::mode_t mode_new;
  logic            on, mode_change, line_end;
  logic            coinc_a, coinc_b, irq_a, irq_b;

  // mode-based status condition
  function automatic logic mode_irq(lsmt_pkg::mode_t m, logic [3:0] en);
    logic r;
    unique case (m)
      lsmt_pkg::MODE_HBLANK: r = en[lsmt_pkg::EN_HBLANK];
      lsmt_pkg::MODE_VBLANK: r = en[lsmt_pkg::EN_VBLANK];
      lsmt_pkg::MODE_OAM:    r = en[lsmt_pkg::EN_OAM];
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

  // mode from the advanced dot count and the line before any increment
  always_comb begin
    on      = item.lcd_on;
    dot_sum = {1'b0, dot_count} + {{(DW + 1 - 8){1'b0}}, item.dots_elapsed};
    priority if (line_count > lsmt_pkg::LAST_VISIBLE_LINE) mode_new = lsmt_pkg::MODE_VBLANK;
    else if (dot_sum < lsmt_pkg::OAM_END)                  mode_new = lsmt_pkg::MODE_OAM;
    else if (dot_sum < lsmt_pkg::XFER_END)                 mode_new = lsmt_pkg::MODE_XFER;
    else                                                   mode_new = lsmt_pkg::MODE_HBLANK;
    mode_change = on && (mode_new != held_mode);
    line_end    = on && (dot_sum >= (DW + 1)'(DOTS_PER_LINE));
  end

  // first status pass, on a mode change
  always_comb begin
    coinc_a = (item.compare_line == line_count) && item.stat_enables[lsmt_pkg::EN_COINC]
              && !compare_fired;
    irq_a   = mode_change && (coinc_a || mode_irq(mode_new, item.stat_enables));
    held_mode_next    = mode_change ? mode_new : held_mode;
    frame_toggle_next = frame_toggle ^ (mode_change && mode_new == lsmt_pkg::MODE_VBLANK);
  end

  // line end: advance and wrap, second status pass with the latch cleared
  always_comb begin
    line_inc     = {1'b0, line_count} + {{LW{1'b0}}, 1'b1};
    line_wrapped = (line_inc >= (LW + 1)'(LINES_PER_FRAME)) ? '0 : line_inc[LW-1:0];
    coinc_b      = (item.compare_line == line_wrapped) && item.stat_enables[lsmt_pkg::EN_COINC];
    irq_b        = line_end && (coinc_b || mode_irq(held_mode_next, item.stat_enables));

    line_count_next    = line_end ? line_wrapped : line_count;
    compare_fired_next = line_end ? coinc_b : (compare_fired || (mode_change && coinc_a));
    if (!on)           dot_count_next = dot_count;
    else if (line_end) dot_count_next = DW'(dot_sum - (DW + 1)'(DOTS_PER_LINE));
    else               dot_count_next = dot_sum[DW-1:0];
  end

  // result beat
  always_comb begin
    res.mode            = held_mode_next;
    res.current_line    = line_count_next;
    res.coincidence     = (item.compare_line == line_count_next);
    res.stat_irq        = irq_a || irq_b;
    res.vblank_irq      = mode_change && mode_new == lsmt_pkg::MODE_VBLANK;
    res.oam_scan_start  = mode_change && frame_toggle_next && mode_new == lsmt_pkg::MODE_OAM;
    res.draw_line_start = mode_change && frame_toggle_next && mode_new == lsmt_pkg::MODE_XFER;
    res.draw_line_index = line_count;
  end

  // state commits when the beat moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count     <= '0;
      line_count    <= '0;
      held_mode     <= lsmt_pkg::MODE_HBLANK;
      frame_toggle  <= 1'b0;
      compare_fired <= 1'b0;
    end else if (step) begin
      dot_count     <= dot_count_next;
      line_count    <= line_count_next;
      held_mode     <= held_mode_next;
      frame_toggle  <= frame_toggle_next;
      compare_fired <= compare_fired_next;
    end
  end

endmodule

`default_nettype wire

>>> src/lcd_scanline_mode_timer.sv
// ---------------------------------------------------------------------------
// lcd_scanline_mode_timer
// Dot/line counter with LCD mode, status and vblank interrupt timing.
//
//   channel  | dir | beat
//   ---------+-----+--------------------------------------------------
//   items    | in  | dots_elapsed, lcd_on, compare_line, stat_enables
//   results  | out | mode, line, coincidence, irqs, strobes, draw line
//
// One beat in per cycle while no result is stalled, one result out per beat;
// each beat: input register, then the single-pass core into the result register.
// The timing state commits as a beat moves into the result register.
// rst clears both valid flags and the timing state.
// A stalled result holds; the input register keeps taking beats until
// it is full behind a result that is still waiting.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lcd_scanline_mode_timer #(
  parameter int DOTS_PER_LINE   = 456,
  parameter int LINES_PER_FRAME = 154
) (
  input wire logic clk,
  input wire logic rst,
  lsmt_stream_if.sink   items,
  lsmt_stream_if.source results
);

  logic              s1_valid;
  lsmt_pkg::item_t   s1_item;
  logic              out_valid;
  lsmt_pkg::result_t out_data;
  lsmt_pkg::result_t core_res;
  logic              advance;

  // handshake
  assign advance       = s1_valid && (!out_valid || results.ready);
  assign items.ready   = !s1_valid || advance;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  lsmt_core #(
    .DOTS_PER_LINE   (DOTS_PER_LINE),
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .res  (core_res)
  );

  // input and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (items.ready) s1_valid <= items.valid;
      if (advance)            out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) s1_item  <= items.data;
    if (advance)                    out_data <= core_res;
  end

  // checks
  `ASSERT_IMPLIES(a_vblank_mode, clk, rst, out_valid && out_data.vblank_irq, out_data.mode == lsmt_pkg::MODE_VBLANK)
  `ASSERT_IMPLIES(a_oam_mode, clk, rst, out_valid && out_data.oam_scan_start, out_data.mode == lsmt_pkg::MODE_OAM)
  `ASSERT_IMPLIES(a_draw_mode, clk, rst, out_valid && out_data.draw_line_start, out_data.mode == lsmt_pkg::MODE_XFER)
  `ASSERT_ALWAYS(a_line_range, clk, rst, !out_valid || (out_data.current_line < 8'(LINES_PER_FRAME) && out_data.draw_line_index < 8'(LINES_PER_FRAME)))

endmodule

`default_nettype wire

>>> tb/sv/tb_lcd_scanline_mode_timer.sv
// ---------------------------------------------------------------------------
// tb_lcd_scanline_mode_timer
// Self-checking bench for the LCD scanline mode timer. A short table of
// directed beats (a few with hand-written results) is followed by random
// beats. The other result beats are compared with a behavioural model of the
// dot/line counters, mode, status and strobe logic kept in this module.
// Both channels idle in random bursts; the result side also holds off for
// a long stretch so that the block fills up, and the item side pauses once
// until everything in flight has drained.
// ---------------------------------------------------------------------------

module tb_lcd_scanline_mode_timer;
  import lsmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DOTS_PER_LINE   = 456;
  localparam int LINES_PER_FRAME = 154;

  localparam int RAND_BEATS   = 1380;
  localparam int PAUSE_AT     = 600;   // item side drains the block here
  localparam int QUIET_FROM   = 1180;  // no idling on either side from here
  localparam int HOLD_BURST   = 30;    // result side holds off after this burst
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_ROWS     = 19;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lsmt_stream_if #(.payload_t(item_t))   item_ch ();
  lsmt_stream_if #(.payload_t(result_t)) res_ch ();

  lcd_scanline_mode_timer #(
    .DOTS_PER_LINE  (DOTS_PER_LINE),
    .LINES_PER_FRAME(LINES_PER_FRAME)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .items  (item_ch.sink),
    .results(res_ch.source)
  );

  // directed table: stimulus beat, and a hand-written result where obvious
  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } step_row_t;

  // fields: dots, lcd_on, compare_line, enables
  // result: mode, line, coincidence, stat, vblank, oam, draw, draw index
  step_row_t dir_rows [DIR_ROWS] = '{
    // LCD off straight after reset: everything held, no events
    '{'{8'd255, 1'b0, 8'd0,   4'hF}, 1'b1,
      '{MODE_HBLANK, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0}},
    '{'{8'd0,   1'b0, 8'd255, 4'h0}, 1'b1,
      '{MODE_HBLANK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0}},
    // switch on: enter OAM scan, coincidence on line 0 fires
    '{'{8'd0,   1'b1, 8'd0,   4'h8}, 1'b1,
      '{MODE_OAM, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0}},
    // coincidence must not fire twice on one line
    '{'{8'd79,  1'b1, 8'd0,   4'hF}, 1'b0, '0},
    '{'{8'd1,   1'b1, 8'd7,   4'h0}, 1'b0, '0},
    '{'{8'd175, 1'b1, 8'd0,   4'hF}, 1'b0, '0},
    '{'{8'd1,   1'b1, 8'd0,   4'h1}, 1'b0, '0},
    '{'{8'd199, 1'b1, 8'd1,   4'h0}, 1'b0, '0},
    // exact line end
    '{'{8'd1,   1'b1, 8'd1,   4'h8}, 1'b0, '0},
    // LCD off mid-line
    '{'{8'd0,   1'b0, 8'd1,   4'hF}, 1'b0, '0},
    '{'{8'd255, 1'b1, 8'd255, 4'h4}, 1'b0, '0},
    // mode change and line end in one beat
    '{'{8'd255, 1'b1, 8'd2,   4'h1}, 1'b0, '0},
    '{'{8'd255, 1'b1, 8'd3,   4'h2}, 1'b0, '0},
    '{'{8'd200, 1'b1, 8'd3,   4'h8}, 1'b0, '0},
    // OAM scan skipped straight into transfer
    '{'{8'd128, 1'b1, 8'd0,   4'h4}, 1'b0, '0},
    '{'{8'd255, 1'b1, 8'd0,   4'hF}, 1'b0, '0},
    '{'{8'd20,  1'b1, 8'd4,   4'hF}, 1'b0, '0},
    '{'{8'd0,   1'b1, 8'd4,   4'hF}, 1'b0, '0},
    '{'{8'd255, 1'b1, 8'd170, 4'h0}, 1'b0, '0}
  };

  // model state
  logic [10:0] dot_cnt;
  logic [7:0]  line_cnt;
  mode_t       cur_mode;
  bit          frame_flag;
  bit          cmp_fired;

  result_t expected_beats [$];
  int unsigned fault_count  = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  bit          quiet_tail;

  // status conditions; sets the compare latch when coincidence fires
  function automatic bit status_raise(input logic [7:0] cmp, input logic [3:0] en);
    bit hit;
    hit = 1'b0;
    if (cmp == line_cnt && en[EN_COINC] && !cmp_fired) begin
      hit       = 1'b1;
      cmp_fired = 1'b1;
    end
    if (cur_mode == MODE_HBLANK && en[EN_HBLANK]) hit = 1'b1;
    if (cur_mode == MODE_VBLANK && en[EN_VBLANK]) hit = 1'b1;
    if (cur_mode == MODE_OAM && en[EN_OAM]) hit = 1'b1;
    return hit;
  endfunction

  // advance the counters by one beat and build the result it produces
  function automatic result_t predict_beat(input item_t it);
    result_t r;
    mode_t   next_mode;
    r = '0;
    r.draw_line_index = line_cnt;
    if (it.lcd_on) begin
      dot_cnt = dot_cnt + 11'(it.dots_elapsed);
      if (line_cnt > LAST_VISIBLE_LINE) next_mode = MODE_VBLANK;
      else if (dot_cnt < OAM_END)       next_mode = MODE_OAM;
      else if (dot_cnt < XFER_END)      next_mode = MODE_XFER;
      else                              next_mode = MODE_HBLANK;
      if (next_mode != cur_mode) begin
        cur_mode = next_mode;
        if (status_raise(it.compare_line, it.stat_enables)) r.stat_irq = 1'b1;
        if (cur_mode == MODE_VBLANK) begin
          frame_flag   = !frame_flag;
          r.vblank_irq = 1'b1;
        end
        if (frame_flag && cur_mode == MODE_OAM)  r.oam_scan_start  = 1'b1;
        if (frame_flag && cur_mode == MODE_XFER) r.draw_line_start = 1'b1;
      end
      // line end: wrap the line first, then re-evaluate with the held mode
      if (dot_cnt >= 11'(DOTS_PER_LINE)) begin
        cmp_fired = 1'b0;
        if (line_cnt >= 8'(LINES_PER_FRAME - 1)) line_cnt = 8'd0;
        else                                     line_cnt = line_cnt + 8'd1;
        if (status_raise(it.compare_line, it.stat_enables)) r.stat_irq = 1'b1;
        dot_cnt = dot_cnt - 11'(DOTS_PER_LINE);
      end
    end
    r.mode         = cur_mode;
    r.current_line = line_cnt;
    r.coincidence  = (it.compare_line == line_cnt);
    return r;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("mode=%0d line=%0d coin=%b stat=%b vb=%b oam=%b draw=%b idx=%0d",
                     r.mode, r.current_line, r.coincidence, r.stat_irq, r.vblank_irq,
                     r.oam_scan_start, r.draw_line_start, r.draw_line_index);
  endfunction

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // offer one beat, with an optional gap first; returns at the accepting edge
  task automatic send_beat(input item_t it, input bit typed, input result_t want);
    result_t model_r;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    model_r = predict_beat(it);
    expected_beats.push_back(typed ? want : model_r);
  endtask

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random ready bursts, one long hold-off
  initial begin : result_sink
    int unsigned bursts;
    int unsigned n;
    bursts = 0;
    res_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      bursts++;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      repeat (n) begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
      if (bursts == HOLD_BURST) begin
        repeat (HOLD_CYCLES) begin
          res_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else if (!quiet_tail && $urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 7)) begin
          res_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      results_seen++;
      if (expected_beats.size() == 0) begin
        flag_fault($sformatf("beat %0d arrived with nothing expected: %s",
                             results_seen, fmt_result(got)));
      end else begin
        want = expected_beats.pop_front();
        if (got.mode !== want.mode ||
            got.current_line !== want.current_line ||
            got.coincidence !== want.coincidence ||
            got.stat_irq !== want.stat_irq ||
            got.vblank_irq !== want.vblank_irq ||
            got.oam_scan_start !== want.oam_scan_start ||
            got.draw_line_start !== want.draw_line_start ||
            got.draw_line_index !== want.draw_line_index)
          flag_fault($sformatf("beat %0d mismatch\n  exp %s\n  got %s",
                               results_seen, fmt_result(want), fmt_result(got)));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    item_t       it;
    int unsigned pick;
    int unsigned i;
    dot_cnt      = '0;
    line_cnt     = '0;
    cur_mode     = MODE_HBLANK;
    frame_flag   = 1'b0;
    cmp_fired    = 1'b0;
    quiet_tail   = 1'b0;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < DIR_ROWS; i++)
      send_beat(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    // random beats, mostly with the LCD on so frames wrap
    for (i = 0; i < RAND_BEATS; i++) begin
      if (i == PAUSE_AT) begin
        item_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
      end
      if (i == QUIET_FROM) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40)      it.dots_elapsed = 8'($urandom_range(0, 255));
      else if (pick < 65) it.dots_elapsed = 8'($urandom_range(0, 40));
      else                it.dots_elapsed = 8'($urandom_range(150, 255));
      it.lcd_on = ($urandom_range(0, 99) >= 7);
      // aim near the current line to hit coincidence often
      if ($urandom_range(0, 1) == 0)
        it.compare_line = line_cnt + 8'($urandom_range(0, 2));
      else
        it.compare_line = 8'($urandom_range(0, 255));
      it.stat_enables = 4'($urandom_range(0, 15));
      send_beat(it, 1'b0, '0);
    end
    item_ch.valid <= 1'b0;

    // drain, then allow for the pipeline latency
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> lcd_scanline_mode_timer.f
+incdir+src
src/lsmt_pkg.sv
src/lsmt_stream_if.sv
src/lsmt_core.sv
src/lcd_scanline_mode_timer.sv
tb/sv/tb_lcd_scanline_mode_timer.sv
